/* src/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg: shared types and microprogram for the running statistics engine
// Holds the control word layout, the sequencer program table and the
// snapshot record that passes a closed run to the arithmetic datapath.
// ----------------------------------------------------------------------------
package rse_pkg;

  // default sample limit per run
  localparam int unsigned MAX_COUNT_DEF = 65535;

  // sequencer sizes
  localparam int unsigned PC_W     = 4;
  localparam int unsigned LOOP_W   = 6;
  localparam int unsigned PROG_LEN = 9;

  // iteration counts of the shared units
  localparam logic [LOOP_W-1:0] MEAN_ITERS = LOOP_W'(32);
  localparam logic [LOOP_W-1:0] AVG_ITERS  = LOOP_W'(48);
  localparam logic [LOOP_W-1:0] SQRT_ITERS = LOOP_W'(16);

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_MEAN,
    OP_DIV_STEP,
    OP_STORE_MEAN,
    OP_LOAD_AVG,
    OP_STORE_VAR,
    OP_SQRT_STEP,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_NO_START,
    JMP_EMPTY,
    JMP_LOOP,
    JMP_BUSY
  } jmp_e;

  // named program steps
  localparam logic [PC_W-1:0] STEP_IDLE      = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_LOAD_MEAN = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_DIV_MEAN  = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_ST_MEAN   = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_LOAD_AVG  = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_DIV_AVG   = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_ST_VAR    = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_SQRT      = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_EMIT      = PC_W'(8);

  typedef struct packed {
    op_e               op;
    jmp_e              jmp;
    logic [PC_W-1:0]   target;
    logic              loop_load;
    logic [LOOP_W-1:0] loop_init;
  } ctl_word_t;

  // status seen by the sequencer
  typedef struct packed {
    logic start;
    logic empty;
    logic busy;
  } seq_cond_t;

  // totals of a closed run
  typedef struct packed {
    logic signed [31:0] sum;
    logic        [47:0] sumsq;
    logic        [15:0] count;
    logic signed [15:0] min;
    logic signed [15:0] max;
    logic               ovf;
  } snap_t;

  // microprogram table
  function automatic ctl_word_t prog_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '{op: OP_NONE, jmp: JMP_NEVER, target: STEP_IDLE, loop_load: 1'b0,
          loop_init: '0};
    case (pc)
      STEP_IDLE: begin
        w.jmp    = JMP_NO_START;
        w.target = STEP_IDLE;
      end
      STEP_LOAD_MEAN: begin
        w.op        = OP_LOAD_MEAN;
        w.jmp       = JMP_EMPTY;
        w.target    = STEP_EMIT;
        w.loop_load = 1'b1;
        w.loop_init = MEAN_ITERS;
      end
      STEP_DIV_MEAN: begin
        w.op     = OP_DIV_STEP;
        w.jmp    = JMP_LOOP;
        w.target = STEP_DIV_MEAN;
      end
      STEP_ST_MEAN: begin
        w.op = OP_STORE_MEAN;
      end
      STEP_LOAD_AVG: begin
        w.op        = OP_LOAD_AVG;
        w.loop_load = 1'b1;
        w.loop_init = AVG_ITERS;
      end
      STEP_DIV_AVG: begin
        w.op     = OP_DIV_STEP;
        w.jmp    = JMP_LOOP;
        w.target = STEP_DIV_AVG;
      end
      STEP_ST_VAR: begin
        w.op        = OP_STORE_VAR;
        w.loop_load = 1'b1;
        w.loop_init = SQRT_ITERS;
      end
      STEP_SQRT: begin
        w.op     = OP_SQRT_STEP;
        w.jmp    = JMP_LOOP;
        w.target = STEP_SQRT;
      end
      STEP_EMIT: begin
        w.op     = OP_EMIT;
        w.jmp    = JMP_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.jmp    = JMP_NEVER;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/rse_accum.sv */
// ----------------------------------------------------------------------------
// rse_accum: per-sample accumulation of sum, sum of squares, count, min, max
// Takes one sample per cycle while accept_i is high; a closing transfer copies the final totals
// into a snapshot for the datapath and restarts the run.
// ----------------------------------------------------------------------------
module rse_accum #(
  parameter int unsigned MaxCount = rse_pkg::MAX_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic signed [15:0] sample_i,
  input  logic               has_sample_i,
  input  logic               is_last_i,
  output rse_pkg::snap_t     snap_o
);

  // effective limit, capped by the count width
  localparam logic [15:0] Limit = (MaxCount > 65535) ? 16'hFFFF : 16'(MaxCount);

  logic signed [31:0] sum_q, sum_d;
  logic        [47:0] sumsq_q, sumsq_d;
  logic        [15:0] count_q, count_d;
  logic signed [15:0] min_q, min_d;
  logic signed [15:0] max_q, max_d;
  logic               ovf_q, ovf_d;
  logic               take;
  logic signed [31:0] square;
  rse_pkg::snap_t     snap_q;

  // updated totals after this transfer
  always_comb begin
    take    = has_sample_i && (count_q < Limit);
    square  = 32'(sample_i) * 32'(sample_i);
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    ovf_d   = ovf_q | (has_sample_i & ~take);
    if (take) begin
      sum_d   = sum_q + {{16{sample_i[15]}}, sample_i};
      sumsq_d = sumsq_q + {16'b0, square};
      count_d = count_q + 16'd1;
      if (sample_i < min_q) min_d = sample_i;
      if (sample_i > max_q) max_d = sample_i;
    end
  end

  // running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      min_q   <= 16'sh7FFF;
      max_q   <= 16'sh8000;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      if (is_last_i) begin
        sum_q   <= '0;
        sumsq_q <= '0;
        count_q <= '0;
        min_q   <= 16'sh7FFF;
        max_q   <= 16'sh8000;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        sumsq_q <= sumsq_d;
        count_q <= count_d;
        min_q   <= min_d;
        max_q   <= max_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // snapshot of a closed run
  always_ff @(posedge clk_i) begin
    if (accept_i && is_last_i) begin
      snap_q <= '{sum: sum_d, sumsq: sumsq_d, count: count_d, min: min_d,
                  max: max_d, ovf: ovf_d};
    end
  end

  assign snap_o = snap_q;

endmodule

/* src/rse_seq.sv */
// ----------------------------------------------------------------------------
// rse_seq: microprogram sequencer
// Step counter over the program table, a loop counter for the iterative
// units and conditional jumps on start, empty run and output stall.
// ----------------------------------------------------------------------------
module rse_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rse_pkg::seq_cond_t  cond_i,
  output rse_pkg::op_e        op_o,
  output logic                idle_o
);

  logic [rse_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [rse_pkg::LOOP_W-1:0] loop_q, loop_d;
  rse_pkg::ctl_word_t         word;
  logic                       jump;

  // control word decode and next step
  always_comb begin
    word = rse_pkg::prog_rom(pc_q);
    case (word.jmp)
      rse_pkg::JMP_NEVER:    jump = 1'b0;
      rse_pkg::JMP_NO_START: jump = ~cond_i.start;
      rse_pkg::JMP_EMPTY:    jump = cond_i.empty;
      rse_pkg::JMP_LOOP:     jump = (loop_q != rse_pkg::LOOP_W'(1));
      rse_pkg::JMP_BUSY:     jump = cond_i.busy;
      default:               jump = 1'b0;
    endcase
    if (jump) begin
      pc_d = word.target;
    end else if (pc_q == rse_pkg::PC_W'(rse_pkg::PROG_LEN - 1)) begin
      pc_d = rse_pkg::STEP_IDLE;
    end else begin
      pc_d = pc_q + rse_pkg::PC_W'(1);
    end
    loop_d = loop_q;
    if (word.loop_load) begin
      loop_d = word.loop_init;
    end else if (word.op == rse_pkg::OP_DIV_STEP || word.op == rse_pkg::OP_SQRT_STEP) begin
      loop_d = loop_q - rse_pkg::LOOP_W'(1);
    end
  end

  // step and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= rse_pkg::STEP_IDLE;
      loop_q <= '0;
    end else begin
      pc_q   <= pc_d;
      loop_q <= loop_d;
    end
  end

  assign op_o   = word.op;
  assign idle_o = (pc_q == rse_pkg::STEP_IDLE);

endmodule

/* src/rse_datapath.sv */
// ----------------------------------------------------------------------------
// rse_datapath: shared divider and square root unit
// Restoring divider (one quotient bit per step) for mean and mean square,
// variance with clamp, and a digit-by-digit square root (two bits a step).
// ----------------------------------------------------------------------------
module rse_datapath (
  input  logic               clk_i,
  input  rse_pkg::op_e       op_i,
  input  rse_pkg::snap_t     snap_i,
  output logic signed [15:0] mean_o,
  output logic        [15:0] std_o
);

  logic        [47:0] quo_q;
  logic        [15:0] rem_q;
  logic               neg_q;
  logic signed [15:0] mean_q;
  logic        [31:0] msq_q;
  logic        [31:0] rad_q;
  logic        [17:0] srem_q;
  logic        [15:0] root_q;

  logic        [16:0] rem_sh;
  logic               div_ge;
  logic        [31:0] abs_sum;
  logic signed [31:0] msq_s;
  logic        [31:0] var_v;
  logic        [19:0] srem_sh;
  logic        [19:0] trial;
  logic               sq_ge;

  // step logic of the shared units
  always_comb begin
    rem_sh  = {rem_q, quo_q[47]};
    div_ge  = (rem_sh >= {1'b0, snap_i.count});
    abs_sum = snap_i.sum[31] ? 32'(-snap_i.sum) : 32'(snap_i.sum);
    msq_s   = 32'(mean_q) * 32'(mean_q);
    var_v   = (quo_q > {16'b0, msq_q}) ? 32'(quo_q - {16'b0, msq_q}) : 32'b0;
    srem_sh = {srem_q, rad_q[31:30]};
    trial   = {2'b0, root_q, 2'b01};
    sq_ge   = (srem_sh >= trial);
  end

  // datapath registers, driven by the current control word
  always_ff @(posedge clk_i) begin
    case (op_i)
      rse_pkg::OP_LOAD_MEAN: begin
        quo_q <= {abs_sum, 16'b0};
        rem_q <= '0;
        neg_q <= snap_i.sum[31];
      end
      rse_pkg::OP_DIV_STEP: begin
        if (div_ge) begin
          rem_q <= 16'(rem_sh - {1'b0, snap_i.count});
          quo_q <= {quo_q[46:0], 1'b1};
        end else begin
          rem_q <= rem_sh[15:0];
          quo_q <= {quo_q[46:0], 1'b0};
        end
      end
      rse_pkg::OP_STORE_MEAN: begin
        mean_q <= neg_q ? -$signed(quo_q[15:0]) : $signed(quo_q[15:0]);
      end
      rse_pkg::OP_LOAD_AVG: begin
        msq_q <= 32'(msq_s);
        quo_q <= snap_i.sumsq;
        rem_q <= '0;
      end
      rse_pkg::OP_STORE_VAR: begin
        rad_q  <= var_v;
        srem_q <= '0;
        root_q <= '0;
      end
      rse_pkg::OP_SQRT_STEP: begin
        rad_q <= {rad_q[29:0], 2'b00};
        if (sq_ge) begin
          srem_q <= 18'(srem_sh - trial);
          root_q <= {root_q[14:0], 1'b1};
        end else begin
          srem_q <= srem_sh[17:0];
          root_q <= {root_q[14:0], 1'b0};
        end
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

  assign mean_o = mean_q;
  assign std_o  = root_q;

endmodule

/* src/running_stats_engine.sv */
// ----------------------------------------------------------------------------
// running_stats_engine: streaming mean, deviation, minimum and maximum
// Accumulates signed Q8.8 samples and reports statistics per closed run.
// ----------------------------------------------------------------------------
// Usage:
//   slave channel: one transfer per item; tdata carries the sample, tuser
//   says whether the transfer holds a sample, tlast closes the run.
//   Transfers without tlast are taken back to back, one per cycle, while the sequencer is idle.
//   master channel: one transfer per closed run with count, mean, standard
//   deviation, min and max in tdata and the dropped-sample flag in tuser.
// Program and input flow:
//   a closing transfer starts the microprogram: 32 mean divide steps,
//   48 mean-square divide steps and 16 square root steps plus five
//   control steps; an empty run jumps from the first load step to the
//   emit step. s_axis_tready stays low while the program runs and rises
//   again in the same cycle in which the result is offered.
// Stall:
//   the result sits in an output register; samples of the next run are
//   taken while it waits, and the next closing transfer waits in the last
//   program step until the register is free.
// Reset:
//   clears the run totals, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module running_stats_engine #(
  parameter int unsigned MaxCount = rse_pkg::MAX_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] has_sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // sample_count, mean_value, std_dev, min_value, max_value
  output logic        m_axis_tuser    // [0] count_overflow
);

  logic               accept;
  logic               idle;
  rse_pkg::op_e       op;
  rse_pkg::snap_t     snap;
  rse_pkg::seq_cond_t cond;
  logic signed [15:0] mean;
  logic        [15:0] std_v;
  logic               out_valid_q;
  logic        [79:0] out_data_q;
  logic               out_user_q;
  logic               empty;
  logic               load_out;

  // input handshake
  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid & s_axis_tready;

  rse_accum #(
    .MaxCount(MaxCount)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    ($signed(s_axis_tdata)),
    .has_sample_i(s_axis_tuser),
    .is_last_i   (s_axis_tlast),
    .snap_o      (snap)
  );

  // sequencer conditions
  assign empty = (snap.count == 16'd0);
  assign cond  = '{start: accept & s_axis_tlast, empty: empty,
                   busy: out_valid_q & ~m_axis_tready};

  rse_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cond_i(cond),
    .op_o  (op),
    .idle_o(idle)
  );

  rse_datapath u_datapath (
    .clk_i (clk_i),
    .op_i  (op),
    .snap_i(snap),
    .mean_o(mean),
    .std_o (std_v)
  );

  assign load_out = (op == rse_pkg::OP_EMIT) && !cond.busy;

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register, zeros for an empty run
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (empty) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {snap.max, snap.min, std_v, mean, snap.count};
      end
      out_user_q <= snap.ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
